// File: src/afa_pkg.sv
// afa_pkg: shared widths, register indexes, request kinds and the
// controller/datapath command and status structs of the frame advance block
// no dependencies
package afa_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam int DT_W    = 24;
   localparam int POS_W   = 32;
   localparam int CYC_W   = 32;
   localparam int RATE_W  = 32;
   localparam int FCNT_W  = 16;
   localparam int DELAY_W = 24;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int FCNT_MIN          = 2;
   localparam int RATE_RESET_FRAMES = 30;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CLIP_ACTIVE  = 3'd0,
      REG_FRAME_COUNT  = 3'd1,
      REG_LOOP_DELAY   = 3'd2,
      REG_FRAME_RATE   = 3'd3,
      REG_LOOPING      = 3'd4,
      REG_STOP_AT_END  = 3'd5,
      REG_BLEND_LOOP   = 3'd6
   } csr_reg_type;

   typedef enum logic {
      REQ_ADVANCE = 1'b0,
      REQ_RESTART = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic load_req;
      logic stage_skip;
      logic do_mul;
      logic do_step;
      logic do_sum;
      logic do_eval;
      logic div_start;
      logic div_step;
      logic do_wrap;
      logic commit;
   } afa_cmd_type;

   typedef struct packed {
      logic skip;
      logic need_div;
      logic div_done;
      logic out_free;
   } afa_status_type;

endpackage

// File: src/afa_req_if.sv
// afa_req_if: request channel of the frame advance block
// depends on afa_pkg for the payload widths
interface afa_req_if;
   import afa_pkg::*;

   logic            valid;
   logic            ready;
   logic            req_type;
   logic [DT_W-1:0] delta_time;

   modport source (output valid, output req_type, output delta_time, input ready);
   modport sink   (input valid, input req_type, input delta_time, output ready);

endinterface

// File: src/afa_rsp_if.sv
// afa_rsp_if: result channel of the frame advance block
// depends on afa_pkg for the payload widths
interface afa_rsp_if;
   import afa_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [POS_W-1:0]        frame_pos;
   logic signed [CYC_W-1:0] cycle_count;
   logic                    at_end;
   logic                    clip_done;

   modport source (output valid, output frame_pos, output cycle_count, output at_end,
                   output clip_done, input ready);
   modport sink   (input valid, input frame_pos, input cycle_count, input at_end,
                   input clip_done, output ready);

endinterface

// File: src/afa_div.sv
// afa_div: restoring unsigned divider, one quotient bit per cycle while step is high
// standalone; used by afa_dp for the loop wrap reduction
module afa_div #(
   parameter int DVD_W = 33,
   parameter int DVS_W = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             step,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient,
   output logic [DVS_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;

   always_comb begin
      trial  = {rem_ff, dvd_ff[DVD_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      if (start) begin
         cnt_in = CNT_W'(DVD_W);
         dvd_in = dividend;
         dvs_in = divisor;
         rem_in = '0;
      end else if (step && cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
         // remainder stays below the divisor, so the top bit drops out
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DVS_W-1:0];
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = (cnt_ff == '0);
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

// File: src/afa_dp.sv
// afa_dp: datapath of the frame advance block: configuration registers,
// step multiplier, position update, wrap divider and result register
// depends on afa_pkg and afa_div
module afa_dp #(
   parameter int FRAC_BITS = afa_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  afa_pkg::afa_cmd_type             cmd,
   output afa_pkg::afa_status_type          status,
   input  logic                             csr_wr_en,
   input  logic [afa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [afa_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_type,
   input  logic [afa_pkg::DT_W-1:0]         delta_time,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [afa_pkg::POS_W-1:0]        frame_pos,
   output logic signed [afa_pkg::CYC_W-1:0] cycle_count,
   output logic                             at_end,
   output logic                             clip_done
);
   import afa_pkg::*;

   localparam int FIX_W   = FCNT_W + FRAC_BITS;
   localparam int FWD_W   = ((FIX_W > DELAY_W) ? FIX_W : DELAY_W) + 1;
   localparam int NP_W    = POS_W + 2;
   localparam int CW      = ((FWD_W > NP_W) ? FWD_W : NP_W) + 1;
   localparam int PROD_W  = RATE_W + DT_W + 1;
   localparam int DVD_W   = POS_W + 1;
   localparam int LAST_W  = (POS_W > FIX_W) ? POS_W : FIX_W;

   localparam logic [PROD_W-1:0] STEP_MAX_MAG = PROD_W'({(RATE_W-1){1'b1}});
   localparam logic [PROD_W-1:0] STEP_MIN_MAG = PROD_W'(1) << (RATE_W - 1);
   localparam logic [POS_W-1:0]  WHOLE_MASK   =
      {{(POS_W-FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}};

   // configuration
   logic                clip_active_ff, clip_active_in;
   logic [FCNT_W-1:0]   frame_count_ff, frame_count_in;
   logic [DELAY_W-1:0]  loop_delay_ff, loop_delay_in;
   logic [RATE_W-1:0]   frame_rate_ff, frame_rate_in;
   logic                looping_ff, looping_in;
   logic                stop_at_end_ff, stop_at_end_in;
   logic                blend_loop_ff, blend_loop_in;

   // architectural state
   logic [POS_W-1:0]    pos_ff;
   logic [CYC_W-1:0]    cycles_ff;
   logic                end_ff;

   // request and work registers
   logic                req_type_ff;
   logic [DT_W-1:0]     dt_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [FWD_W-1:0]    period_ff, period_in;
   logic [FWD_W-1:0]    limit_ff, limit_in;
   logic signed [RATE_W-1:0] step_ff, step_in;
   logic signed [NP_W-1:0]   np_ff, np_in;
   logic [CW-1:0]       cand_pos_ff, cand_pos_in;
   logic [CYC_W-1:0]    cand_cyc_ff, cand_cyc_in;
   logic                cand_end_ff, cand_end_in;

   // result register
   logic                rsp_valid_ff;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [CYC_W-1:0]    rsp_cyc_ff;
   logic                rsp_end_ff;
   logic                rsp_done_ff, rsp_done_in;

   logic [FCNT_W-1:0]   frames_eff;
   logic [FWD_W-1:0]    fwd;
   logic [FWD_W-1:0]    one_fx;
   logic [PROD_W-1:0]   prod_mag;
   logic [PROD_W-1:0]   step_mag;
   logic signed [CW-1:0] np_c, per_c, lim_c;
   logic                over_lim, over_per, under;
   logic                clamp_stop;
   logic [DVD_W-1:0]    div_dividend;
   logic [NP_W-1:0]     np_m1;
   logic                div_done;
   logic [DVD_W-1:0]    div_quot;
   logic [FWD_W-1:0]    div_rem;
   logic [POS_W-1:0]    sat_pos;
   logic [LAST_W-1:0]   last_fx;

   afa_div #(
      .DVD_W (DVD_W),
      .DVS_W (FWD_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .step      (cmd.div_step),
      .dividend  (div_dividend),
      .divisor   (period_ff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // configuration writes
   always_comb begin
      clip_active_in = clip_active_ff;
      frame_count_in = frame_count_ff;
      loop_delay_in  = loop_delay_ff;
      frame_rate_in  = frame_rate_ff;
      looping_in     = looping_ff;
      stop_at_end_in = stop_at_end_ff;
      blend_loop_in  = blend_loop_ff;
      if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            REG_CLIP_ACTIVE: clip_active_in = csr_wdata[0];
            REG_FRAME_COUNT: frame_count_in = csr_wdata[FCNT_W-1:0];
            REG_LOOP_DELAY:  loop_delay_in  = csr_wdata[DELAY_W-1:0];
            REG_FRAME_RATE:  frame_rate_in  = csr_wdata[RATE_W-1:0];
            REG_LOOPING:     looping_in     = csr_wdata[0];
            REG_STOP_AT_END: stop_at_end_in = csr_wdata[0];
            REG_BLEND_LOOP:  blend_loop_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // loop period, stop limit and rate by time product
   always_comb begin
      frames_eff = (frame_count_ff < FCNT_W'(FCNT_MIN)) ? FCNT_W'(FCNT_MIN) : frame_count_ff;
      one_fx     = FWD_W'(1) << FRAC_BITS;
      fwd        = (FWD_W'(frames_eff) << FRAC_BITS) + FWD_W'(loop_delay_ff);
      period_in  = fwd - one_fx;
      limit_in   = fwd - (one_fx << 1);
      prod_in    = $signed(frame_rate_ff) * $signed({1'b0, dt_ff});
   end

   // step: truncate toward zero, then saturate; new position sum
   always_comb begin
      prod_mag = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      step_mag = prod_mag >> FRAC_BITS;
      if (!prod_ff[PROD_W-1]) begin
         step_in = (step_mag > STEP_MAX_MAG) ? $signed(STEP_MAX_MAG[RATE_W-1:0])
                                             : $signed(step_mag[RATE_W-1:0]);
      end else begin
         step_in = (step_mag > STEP_MIN_MAG) ? $signed(STEP_MIN_MAG[RATE_W-1:0])
                                             : $signed(-step_mag[RATE_W-1:0]);
      end
      np_in = $signed({2'b00, pos_ff}) + $signed({{(NP_W-RATE_W){step_ff[RATE_W-1]}}, step_ff});
   end

   // end handling
   always_comb begin
      np_c       = $signed({{(CW-NP_W){np_ff[NP_W-1]}}, np_ff});
      per_c      = $signed({{(CW-FWD_W){1'b0}}, period_ff});
      lim_c      = $signed({{(CW-FWD_W){1'b0}}, limit_ff});
      over_lim   = (np_c > lim_c);
      over_per   = (np_c > per_c);
      under      = np_ff[NP_W-1];
      clamp_stop = stop_at_end_ff && (over_lim || under);
      np_m1      = np_ff - NP_W'(1);
      // negative side divides -np-1, positive side np-1
      div_dividend = under ? ~np_ff[DVD_W-1:0] : np_m1[DVD_W-1:0];
   end

   // candidate next state
   always_comb begin
      cand_pos_in = cand_pos_ff;
      cand_cyc_in = cand_cyc_ff;
      cand_end_in = cand_end_ff;
      if (cmd.stage_skip) begin
         if (req_type_ff == REQ_RESTART) begin
            cand_pos_in = '0;
            cand_cyc_in = '0;
            cand_end_in = 1'b0;
         end else begin
            cand_pos_in = CW'(pos_ff);
            cand_cyc_in = cycles_ff;
            cand_end_in = end_ff;
         end
      end else if (cmd.do_eval) begin
         cand_end_in = 1'b0;
         cand_cyc_in = cycles_ff;
         priority if (stop_at_end_ff && over_lim) begin
            cand_pos_in = CW'(limit_ff);
            cand_end_in = 1'b1;
         end else if (stop_at_end_ff && under) begin
            cand_pos_in = '0;
            cand_end_in = 1'b1;
         end else if (over_per) begin
            cand_pos_in = CW'(period_ff);
            cand_cyc_in = '0;
         end else if (under) begin
            cand_pos_in = '0;
            cand_cyc_in = '0;
         end else begin
            cand_pos_in = CW'(np_ff[NP_W-2:0]);
         end
      end else if (cmd.do_wrap) begin
         cand_end_in = 1'b0;
         if (under) begin
            cand_pos_in = CW'(period_ff - FWD_W'(1) - div_rem);
            cand_cyc_in = cycles_ff - div_quot[CYC_W-1:0] - CYC_W'(1);
         end else begin
            cand_pos_in = CW'(div_rem) + CW'(1);
            cand_cyc_in = cycles_ff + div_quot[CYC_W-1:0];
         end
      end
   end

   // saturate, floor on cycle change unless blend loop is on, completion flag
   always_comb begin
      sat_pos = (|cand_pos_ff[CW-1:POS_W]) ? '1 : cand_pos_ff[POS_W-1:0];
      rsp_pos_in = sat_pos;
      if (cand_cyc_ff != cycles_ff && !blend_loop_ff) begin
         rsp_pos_in = sat_pos & WHOLE_MASK;
      end
      last_fx     = LAST_W'(frames_eff - FCNT_W'(1)) << FRAC_BITS;
      rsp_done_in = !looping_ff && (cand_end_ff || (LAST_W'(rsp_pos_in) >= last_fx));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_active_ff <= 1'b0;
         frame_count_ff <= FCNT_W'(FCNT_MIN);
         loop_delay_ff  <= '0;
         frame_rate_ff  <= RATE_W'(RATE_RESET_FRAMES) << FRAC_BITS;
         looping_ff     <= 1'b1;
         stop_at_end_ff <= 1'b0;
         blend_loop_ff  <= 1'b1;
         pos_ff         <= '0;
         cycles_ff      <= '0;
         end_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         clip_active_ff <= clip_active_in;
         frame_count_ff <= frame_count_in;
         loop_delay_ff  <= loop_delay_in;
         frame_rate_ff  <= frame_rate_in;
         looping_ff     <= looping_in;
         stop_at_end_ff <= stop_at_end_in;
         blend_loop_ff  <= blend_loop_in;
         if (cmd.commit) begin
            pos_ff       <= rsp_pos_in;
            cycles_ff    <= cand_cyc_ff;
            end_ff       <= cand_end_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_type_ff <= req_type;
         dt_ff       <= delta_time;
      end
      if (cmd.do_mul) begin
         prod_ff   <= prod_in;
         period_ff <= period_in;
         limit_ff  <= limit_in;
      end
      if (cmd.do_step) begin
         step_ff <= step_in;
      end
      if (cmd.do_sum) begin
         np_ff <= np_in;
      end
      cand_pos_ff <= cand_pos_in;
      cand_cyc_ff <= cand_cyc_in;
      cand_end_ff <= cand_end_in;
      if (cmd.commit) begin
         rsp_pos_ff  <= rsp_pos_in;
         rsp_cyc_ff  <= cand_cyc_ff;
         rsp_end_ff  <= cand_end_ff;
         rsp_done_ff <= rsp_done_in;
      end
   end

   always_comb begin
      status.skip     = (req_type_ff == REQ_RESTART) || !clip_active_ff ||
                        (dt_ff == '0) || (frame_rate_ff == '0);
      status.need_div = !clamp_stop && looping_ff && (over_per || under);
      status.div_done = div_done;
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign frame_pos   = rsp_pos_ff;
   assign cycle_count = $signed(rsp_cyc_ff);
   assign at_end      = rsp_end_ff;
   assign clip_done   = rsp_done_ff;

endmodule

// File: src/afa_ctrl.sv
// afa_ctrl: sequencing state machine of the frame advance block
// depends on afa_pkg for the command and status structs
module afa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  afa_pkg::afa_status_type status,
   output afa_pkg::afa_cmd_type    cmd
);
   import afa_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_STEP,
      ST_SUM,
      ST_EVAL,
      ST_DIV,
      ST_WRAP,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_req = req_valid;
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // restart and no-op advances go straight to the result
            if (status.skip) begin
               cmd.stage_skip = 1'b1;
               state_in       = ST_FINISH;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.do_mul = 1'b1;
            state_in   = ST_STEP;
         end
         ST_STEP: begin
            cmd.do_step = 1'b1;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            cmd.do_sum = 1'b1;
            state_in   = ST_EVAL;
         end
         ST_EVAL: begin
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.do_eval = 1'b1;
               state_in    = ST_FINISH;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_WRAP;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_WRAP: begin
            cmd.do_wrap = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the result register is free
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

// File: src/anim_frame_advance_core.sv
// anim_frame_advance_core: top level of the clip frame position accumulator
// depends on afa_pkg, afa_req_if, afa_rsp_if, afa_ctrl, afa_dp, afa_div
//
// One request at a time. A restart, or an advance with no clip, zero time or
// zero rate, goes from the check straight to the store into the result
// register. A normal advance steps through: check the request, multiply rate
// by time, truncate and saturate the step, add it to the position, resolve
// the ends, store. With looping on and stop at end off, a new position beyond
// one loop period or below zero is wrapped before the store by a restoring
// divider that yields one quotient bit per cycle. The block takes the next
// request in its idle state, after the result is stored. A new request is
// taken while the previous result still waits in the output register; the
// block then holds before writing the next result until that one is taken.
module anim_frame_advance_core #(
   parameter int FRAC_BITS = afa_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   afa_req_if.sink                        req_ch,
   afa_rsp_if.source                      rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [afa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [afa_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import afa_pkg::*;

   afa_cmd_type    cmd;
   afa_status_type status;

   afa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   afa_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_type    (req_ch.req_type),
      .delta_time  (req_ch.delta_time),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .frame_pos   (rsp_ch.frame_pos),
      .cycle_count (rsp_ch.cycle_count),
      .at_end      (rsp_ch.at_end),
      .clip_done   (rsp_ch.clip_done)
   );

endmodule
